### hdl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Used by ffha_cell, ffha_scan_node and first_fit_heap_allocator.
package ffha_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 3;

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BAD      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOFIT    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_GAP  = 7'b0000010,
    ST_LEN  = 7'b0000100,
    ST_HIT  = 7'b0001000,
    ST_INIT = 7'b0010000,
    ST_SCAN = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic cap_gap;
    logic cap_len;
    logic cap_hit;
    logic scan_init;
    logic scan_en;
    logic op_free;
  } ctrl_t;

endpackage

### hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: APB register port, sequencer,
// a row of ffha_cell table cells and a row of ffha_scan_node scan nodes.
// Depends on ffha_pkg, ffha_cell and ffha_scan_node.
//
// Usage:
//   Program heap_base (0x0) and heap_limit (0x4) over the APB port while idle.
//   Send allocate or free transactions on the input channel (in_valid/in_ready);
//   each one returns exactly one transaction on the output channel with
//   granted_address and status.
//   Each transaction passes from acceptance to the result register through
//   gap start, gap length, hit flags, scan load, then one doubling step of
//   the scan row per cycle. One transaction is in flight at a time: a new one
//   is accepted only once the sequencer is back in idle after the last one.
//   in_ready is high while the sequencer is idle, also while a result waits.
//   A stalled receiver holds the result; the sequencer then holds in its
//   final state until the result register frees, leaving the table untouched.
//   Reset empties the table, clears both heap registers and drops any result.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [ffha_pkg::DATA_W-1:0]   request_size,
  input  logic [ffha_pkg::DATA_W-1:0]   free_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffha_pkg::DATA_W-1:0]   granted_address,
  output logic [ffha_pkg::STAT_W-1:0]   status
);
  import ffha_pkg::*;

  localparam int unsigned N  = MAX_ENTRIES;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned L  = $clog2(N);
  localparam int unsigned SW = (L > 1) ? $clog2(L) : 1;
  localparam int unsigned LP = 1 << SW;

  state_t              state;
  state_t              state_next;
  logic [DATA_W-1:0]   heap_base;
  logic [DATA_W-1:0]   heap_limit;
  logic [DATA_W-1:0]   heap_span;
  logic [CW-1:0]       entry_count;
  logic                op;
  logic [DATA_W-1:0]   req;
  logic [DATA_W-1:0]   addr;
  logic [STAT_W-1:0]   pre_status;
  logic [SW-1:0]       step;
  ctrl_t               ctrl;

  logic [N-1:0]        hit;
  logic [N-1:0]        pfx;
  logic [N-1:0]        sf;
  logic [N-1:0]        first;
  logic [N-1:0]        ld;
  logic [N-1:0]        sh_up;
  logic [N-1:0]        sh_dn;
  logic [DATA_W-1:0]   base [N];
  logic [DATA_W-1:0]   size [N];
  logic [DATA_W-1:0]   gs   [N];
  logic [DATA_W-1:0]   sv   [N];

  logic                done_go;
  logic                empty;
  logic                commit_alloc;
  logic                commit_free;
  logic                cfg_wr;

  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_limit <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_HEAP_BASE:  heap_base  <= pwdata;
        REG_HEAP_LIMIT: heap_limit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_HEAP_BASE:  prdata = heap_base;
      REG_HEAP_LIMIT: prdata = heap_limit;
      default:        prdata = '0;
    endcase
  end

  // Sequencer
  assign in_ready     = state == ST_IDLE;
  assign done_go      = (state == ST_DONE) & (~out_valid | out_ready);
  assign empty        = entry_count == '0;
  assign commit_alloc = done_go & (op == OP_ALLOC) & (pre_status == STAT_OK) & (empty | sf[0]);
  assign commit_free  = done_go & (op == OP_FREE) & pfx[N-1];

  assign ctrl.cap_gap   = state == ST_GAP;
  assign ctrl.cap_len   = state == ST_LEN;
  assign ctrl.cap_hit   = state == ST_HIT;
  assign ctrl.scan_init = state == ST_INIT;
  assign ctrl.scan_en   = state == ST_SCAN;
  assign ctrl.op_free   = op == OP_FREE;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_GAP;
      ST_GAP:  state_next = ST_LEN;
      ST_LEN:  state_next = ST_HIT;
      ST_HIT:  state_next = ST_INIT;
      ST_INIT: state_next = ST_SCAN;
      ST_SCAN: if (step == SW'(L - 1)) state_next = ST_DONE;
      ST_DONE: if (done_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (commit_alloc) begin
        entry_count <= entry_count + CW'(1);
      end else if (commit_free) begin
        entry_count <= entry_count - CW'(1);
      end
      if (done_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op   <= operation;
      req  <= request_size;
      addr <= free_address;
    end
    if (state == ST_GAP) begin
      heap_span <= heap_limit - heap_base;
    end
    if (state == ST_LEN) begin
      if (heap_base == '0 || heap_limit == '0 || req == '0) begin
        pre_status <= STAT_BAD;
      end else if (entry_count >= CW'(N - 1)) begin
        pre_status <= STAT_FULL;
      end else if (req > heap_span) begin
        pre_status <= STAT_BAD;
      end else begin
        pre_status <= STAT_OK;
      end
    end
    if (state == ST_INIT) begin
      step <= '0;
    end else if (state == ST_SCAN) begin
      step <= step + SW'(1);
    end
    if (done_go) begin
      if (op == OP_FREE) begin
        granted_address <= '0;
        status          <= pfx[N-1] ? STAT_OK : STAT_NOTFOUND;
      end else if (pre_status != STAT_OK) begin
        granted_address <= '0;
        status          <= pre_status;
      end else if (empty) begin
        granted_address <= heap_base;
        status          <= STAT_OK;
      end else if (sf[0]) begin
        granted_address <= sv[0];
        status          <= STAT_OK;
      end else begin
        granted_address <= '0;
        status          <= STAT_NOFIT;
      end
    end
  end

  // Cell and scan rows
  for (genvar i = 0; i < N; i++) begin : g_row
    logic [DATA_W-1:0]            next_base;
    logic [DATA_W-1:0]            new_base;
    logic [DATA_W-1:0]            left_base;
    logic [DATA_W-1:0]            left_size;
    logic [DATA_W-1:0]            right_base;
    logic [DATA_W-1:0]            right_size;
    logic [LP-1:0]                lp;
    logic [LP-1:0]                rf;
    logic [LP-1:0][DATA_W-1:0]    rv;

    if (i == 0) begin : g_head
      assign first[i]  = hit[i];
      assign ld[i]     = commit_alloc & empty;
      assign new_base  = heap_base;
      assign left_base = base[i];
      assign left_size = size[i];
    end else begin : g_body
      assign first[i]  = hit[i] & ~pfx[i-1];
      assign ld[i]     = commit_alloc & first[i-1];
      assign new_base  = gs[i-1];
      assign left_base = base[i-1];
      assign left_size = size[i-1];
    end

    if (i >= 2) begin : g_up
      assign sh_up[i] = commit_alloc & pfx[i-2];
    end else begin : g_no_up
      assign sh_up[i] = 1'b0;
    end

    assign sh_dn[i] = commit_free & pfx[i];

    if (i + 1 < N) begin : g_next
      assign next_base  = base[i+1];
      assign right_base = base[i+1];
      assign right_size = size[i+1];
    end else begin : g_tail
      assign next_base  = '0;
      assign right_base = base[i];
      assign right_size = size[i];
    end

    for (genvar k = 0; k < LP; k++) begin : g_lvl
      if (k < L && i >= (1 << k)) begin : g_left
        assign lp[k] = pfx[i - (1 << k)];
      end else begin : g_no_left
        assign lp[k] = 1'b0;
      end
      if (k < L && i + (1 << k) < N) begin : g_right
        assign rf[k] = sf[i + (1 << k)];
        assign rv[k] = sv[i + (1 << k)];
      end else begin : g_no_right
        assign rf[k] = 1'b0;
        assign rv[k] = '0;
      end
    end

    ffha_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (entry_count),
      .heap_limit (heap_limit),
      .req        (req),
      .addr       (addr),
      .next_base  (next_base),
      .ld         (ld[i]),
      .sh_up      (sh_up[i]),
      .sh_dn      (sh_dn[i]),
      .new_base   (new_base),
      .left_base  (left_base),
      .left_size  (left_size),
      .right_base (right_base),
      .right_size (right_size),
      .base       (base[i]),
      .size       (size[i]),
      .gap_start  (gs[i]),
      .hit        (hit[i])
    );

    ffha_scan_node #(
      .LP (LP),
      .SW (SW)
    ) u_scan (
      .clk     (clk),
      .ctrl    (ctrl),
      .step    (step),
      .hit     (hit[i]),
      .value   (gs[i]),
      .left_p  (lp),
      .right_f (rf),
      .right_v (rv),
      .p       (pfx[i]),
      .f       (sf[i]),
      .v       (sv[i])
    );
  end

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(N - 1))
    else $error("entry count above table capacity");

  a_first_unique: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> $onehot0(first))
    else $error("more than one first hit");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> granted_address == '0)
    else $error("nonzero address on failed transaction");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    done_go |=> (entry_count == $past(entry_count)) ||
                (entry_count == $past(entry_count) + CW'(1)) ||
                (entry_count + CW'(1) == $past(entry_count)))
    else $error("entry count moved by more than one");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    state != ST_DONE |=> entry_count == $past(entry_count))
    else $error("table changed outside commit");

endmodule

### hdl/ffha_cell.sv
// One table cell: holds an entry, computes the gap behind it and its hit flag.
// Shifts entries with its neighbors on insert and remove. Depends on ffha_pkg.
module ffha_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 9
) (
  input  logic                          clk,
  input  ffha_pkg::ctrl_t               ctrl,
  input  logic [CW-1:0]                 count,
  input  logic [ffha_pkg::DATA_W-1:0]   heap_limit,
  input  logic [ffha_pkg::DATA_W-1:0]   req,
  input  logic [ffha_pkg::DATA_W-1:0]   addr,
  input  logic [ffha_pkg::DATA_W-1:0]   next_base,
  input  logic                          ld,
  input  logic                          sh_up,
  input  logic                          sh_dn,
  input  logic [ffha_pkg::DATA_W-1:0]   new_base,
  input  logic [ffha_pkg::DATA_W-1:0]   left_base,
  input  logic [ffha_pkg::DATA_W-1:0]   left_size,
  input  logic [ffha_pkg::DATA_W-1:0]   right_base,
  input  logic [ffha_pkg::DATA_W-1:0]   right_size,
  output logic [ffha_pkg::DATA_W-1:0]   base,
  output logic [ffha_pkg::DATA_W-1:0]   size,
  output logic [ffha_pkg::DATA_W-1:0]   gap_start,
  output logic                          hit
);
  import ffha_pkg::*;

  logic [DATA_W-1:0] gap_len;
  logic [DATA_W-1:0] gap_end;
  logic              active;
  logic              is_last;

  assign active  = count > CW'(IDX);
  assign is_last = count == CW'(IDX + 1);
  assign gap_end = is_last ? heap_limit : next_base;

  always_ff @(posedge clk) begin
    if (ld) begin
      base <= new_base;
      size <= req;
    end else if (sh_up) begin
      base <= left_base;
      size <= left_size;
    end else if (sh_dn) begin
      base <= right_base;
      size <= right_size;
    end
    if (ctrl.cap_gap) begin
      gap_start <= base + size;
    end
    if (ctrl.cap_len) begin
      gap_len <= gap_end - gap_start;
    end
    if (ctrl.cap_hit) begin
      hit <= active & (ctrl.op_free ? (base == addr) : (gap_len > req));
    end
  end

endmodule

### hdl/ffha_scan_node.sv
// One node of the doubling scan: inclusive prefix-OR of hits from the left,
// and first-hit value from the right with lower index winning. Depends on ffha_pkg.
module ffha_scan_node #(
  parameter int unsigned LP = 8,
  parameter int unsigned SW = 3
) (
  input  logic                                clk,
  input  ffha_pkg::ctrl_t                     ctrl,
  input  logic [SW-1:0]                       step,
  input  logic                                hit,
  input  logic [ffha_pkg::DATA_W-1:0]         value,
  input  logic [LP-1:0]                       left_p,
  input  logic [LP-1:0]                       right_f,
  input  logic [LP-1:0][ffha_pkg::DATA_W-1:0] right_v,
  output logic                                p,
  output logic                                f,
  output logic [ffha_pkg::DATA_W-1:0]         v
);
  import ffha_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.scan_init) begin
      p <= hit;
      f <= hit;
      v <= value;
    end else if (ctrl.scan_en) begin
      p <= p | left_p[step];
      if (!f) begin
        f <= right_f[step];
        v <= right_v[step];
      end
    end
  end

endmodule

### verif/ffha_alloc_checker.sv
// Result checker of first_fit_heap_allocator: follows register writes and
// requests, keeps its own allocation table and compares every result.
// Depends on ffha_pkg; instantiated by tb_top beside the block.
module ffha_alloc_checker #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          operation,
  input  logic [ffha_pkg::DATA_W-1:0]   request_size,
  input  logic [ffha_pkg::DATA_W-1:0]   free_address,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ffha_pkg::DATA_W-1:0]   granted_address,
  input  logic [ffha_pkg::STAT_W-1:0]   status,
  output int                            mismatch_count,
  output int                            pending_grants
);
  import ffha_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] addr;
    logic [STAT_W-1:0] stat;
  } grant_t;

  logic [DATA_W-1:0] heap_lo;
  logic [DATA_W-1:0] heap_hi;
  logic [DATA_W-1:0] blk_base [TABLE_DEPTH];
  logic [DATA_W-1:0] blk_size [TABLE_DEPTH];
  int unsigned       blk_count;
  grant_t            expected_grants [$];
  int                errors;
  int                checked;

  function automatic void insert_block(int unsigned at, logic [DATA_W-1:0] b,
                                       logic [DATA_W-1:0] s);
    int unsigned i;
    for (i = blk_count; i > at; i--) begin
      blk_base[i] = blk_base[i-1];
      blk_size[i] = blk_size[i-1];
    end
    blk_base[at] = b;
    blk_size[at] = s;
    blk_count++;
  endfunction

  function automatic void remove_block(int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < blk_count; i++) begin
      blk_base[i] = blk_base[i+1];
      blk_size[i] = blk_size[i+1];
    end
    blk_count--;
  endfunction

  function automatic grant_t serve_request(logic op, logic [DATA_W-1:0] req,
                                           logic [DATA_W-1:0] addr);
    grant_t            r;
    logic [DATA_W-1:0] window;
    logic [DATA_W-1:0] gap_start;
    logic [DATA_W-1:0] gap_len;
    bit                done;
    int unsigned       i;
    r.addr = '0;
    r.stat = STAT_OK;
    done = 1'b0;
    window = heap_hi - heap_lo;
    if (op == OP_FREE) begin
      r.stat = STAT_NOTFOUND;
      for (i = 0; i < blk_count && !done; i++) begin
        if (blk_base[i] == addr) begin
          remove_block(i);
          r.stat = STAT_OK;
          done = 1'b1;
        end
      end
    end else if (heap_lo == '0 || heap_hi == '0 || req == '0) begin
      r.stat = STAT_BAD;
    end else if (blk_count >= TABLE_DEPTH - 1) begin
      r.stat = STAT_FULL;
    end else if (req > window) begin
      r.stat = STAT_BAD;
    end else if (blk_count == 0) begin
      insert_block(0, heap_lo, req);
      r.addr = heap_lo;
    end else begin
      for (i = 0; i + 1 < blk_count && !done; i++) begin
        gap_start = blk_base[i] + blk_size[i];
        gap_len = blk_base[i+1] - gap_start;
        if (gap_len > req) begin
          insert_block(i + 1, gap_start, req);
          r.addr = gap_start;
          done = 1'b1;
        end
      end
      if (!done) begin
        gap_start = blk_base[blk_count-1] + blk_size[blk_count-1];
        gap_len = heap_hi - gap_start;
        if (gap_len > req) begin
          insert_block(blk_count, gap_start, req);
          r.addr = gap_start;
          done = 1'b1;
        end
      end
      r.stat = done ? STAT_OK : STAT_NOFIT;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      heap_lo = '0;
      heap_hi = '0;
      blk_count = 0;
      errors = 0;
      checked = 0;
      expected_grants.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_grants.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: granted_address %h status %0d",
                     granted_address, status);
          errors++;
        end else begin
          want = expected_grants.pop_front();
          if (granted_address !== want.addr || status !== want.stat) begin
            if (errors < 10)
              $display("result %0d: expected granted_address %h status %0d, got %h status %0d",
                       checked, want.addr, want.stat, granted_address, status);
            errors++;
          end
        end
        checked++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_HEAP_BASE)
          heap_lo = pwdata;
        else
          heap_hi = pwdata;
      end
      if (in_valid && in_ready)
        expected_grants.push_back(serve_request(operation, request_size, free_address));
    end
    mismatch_count <= errors;
    pending_grants <= expected_grants.size();
  end

endmodule

### verif/tb_top.sv
// Testbench top of first_fit_heap_allocator: clock, reset, register setup,
// request stimulus in bursts, result-side stalls and the final verdict.
// Depends on ffha_pkg, first_fit_heap_allocator and ffha_alloc_checker.
module tb_top;
  import ffha_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              operation = OP_ALLOC;
  logic [DATA_W-1:0] request_size = '0;
  logic [DATA_W-1:0] free_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] granted_address;
  logic [STAT_W-1:0] status;

  int                mismatch_count;
  int                pending_grants;
  logic [DATA_W-1:0] live_pool [$];
  int unsigned       burst_left = 0;
  bit                hold_out = 1'b0;

  always #2 clk = ~clk;

  first_fit_heap_allocator #(.MAX_ENTRIES(TABLE_DEPTH)) dut (.*);

  ffha_alloc_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready && status == STAT_OK && granted_address != '0)
      live_pool.push_back(granted_address);
  end

  initial begin : result_sink
    int unsigned mode;
    int unsigned tick;
    mode = 0;
    tick = 0;
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        if (tick % 64 == 0)
          mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 8 < 3);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input logic op, input logic [DATA_W-1:0] size,
                              input logic [DATA_W-1:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    operation <= op;
    request_size <= size;
    free_address <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_grants != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic random_request(input int unsigned alloc_pct,
                                input logic [DATA_W-1:0] max_size);
    int unsigned       roll;
    int unsigned       pick;
    logic [DATA_W-1:0] addr;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      send_request(1'($urandom_range(0, 1)), $urandom, $urandom);
    end else if (roll < 6 + alloc_pct) begin
      send_request(OP_ALLOC, $urandom_range(1, max_size), $urandom);
    end else begin
      if (live_pool.size() != 0 && $urandom_range(0, 9) != 0) begin
        pick = $urandom_range(0, live_pool.size() - 1);
        addr = live_pool[pick];
        live_pool.delete(pick);
      end else begin
        addr = $urandom;
      end
      send_request(OP_FREE, $urandom, addr);
    end
  endtask

  task automatic release_all();
    logic [DATA_W-1:0] addr;
    wait_drained();
    while (live_pool.size() != 0) begin
      addr = live_pool.pop_front();
      send_request(OP_FREE, '0, addr);
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    send_request(OP_ALLOC, 32'd1, '0);
    send_request(OP_FREE, 32'hFFFF_FFFF, '0);
    send_request(OP_FREE, '0, 32'hFFFF_FFFF);
    wait_drained();
    write_reg(REG_HEAP_BASE, 32'h0000_1000);
    send_request(OP_ALLOC, 32'd4, '0);
    wait_drained();
    write_reg(REG_HEAP_LIMIT, 32'h0000_2000);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_ALLOC, 32'h1001, '0);
    send_request(OP_ALLOC, 32'h1000, '0);
    send_request(OP_ALLOC, 32'h10, '0);
    send_request(OP_FREE, '0, 32'h1000);
    repeat (3) send_request(OP_ALLOC, 32'h100, '0);
    send_request(OP_FREE, '0, 32'h1100);
    send_request(OP_ALLOC, 32'h80, '0);
    send_request(OP_ALLOC, 32'h80, '0);
    send_request(OP_FREE, '0, 32'h1000);
    send_request(OP_ALLOC, 32'h10, '0);
    send_request(OP_ALLOC, 32'hFFFF_FFFF, '0);
    send_request(OP_FREE, '0, 32'hFFFF_FFFF);

    // wrapped window
    wait_drained();
    write_reg(REG_HEAP_BASE, 32'hFFFF_F000);
    write_reg(REG_HEAP_LIMIT, 32'h0000_1000);
    release_all();
    repeat (40) random_request(65, 32'h200);

    wait_drained();
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    repeat (10) random_request(80, 32'hFFFF);

    wait_drained();
    write_reg(REG_HEAP_BASE, 32'h0000_0001);
    release_all();
    repeat (30) random_request(70, 32'h1000_0000);

    wait_drained();
    write_reg(REG_HEAP_BASE, 32'h0010_0000);
    write_reg(REG_HEAP_LIMIT, 32'h0011_0000);
    release_all();
    hold_out = 1'b1;
    repeat (45) random_request(60, 32'h800);
    wait_drained();
    repeat (45) random_request(60, 32'h800);

    // fill the table past its limit
    wait_drained();
    write_reg(REG_HEAP_LIMIT, 32'h0100_0000);
    repeat (265) send_request(OP_ALLOC, $urandom_range(1, 16), $urandom);
    repeat (90) random_request(40, 32'h40);

    wait_drained();
    write_reg(REG_HEAP_BASE, 32'h0000_0000);
    repeat (10) random_request(50, 32'h40);

    wait_drained();
    if (mismatch_count == 0 && pending_grants == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
hdl/ffha_pkg.sv
hdl/ffha_cell.sv
hdl/ffha_scan_node.sv
hdl/first_fit_heap_allocator.sv
verif/ffha_alloc_checker.sv
verif/tb_top.sv
